@@ design/rm_pkg.sv @@
`default_nettype none

package rm_pkg;

    // Default geometry
    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Sample and register widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_GAIN = 8'd1;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST   = 32'd161061274;
    localparam logic [GAIN_W-1:0] CARRIER_GAIN_RST = 16'd16384;

    // Carrier gain (u16) times sine (s16): signed 33 bits
    localparam int GS_W   = GAIN_W + SAMPLE_W + 1;
    // Times the audio sample: signed 49 bits, Q20.29
    localparam int PROD_W = GS_W + SAMPLE_W;
    localparam int FRAC_W = 29;

    // Sine constants in Q30
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // request taken: latch sample, read sine, step phase
        logic gain;   // gain times sine
        logic mix;    // times sample, truncate, saturate into output register
    } rm_cmd_t;

    // Shift-subtract divide, used only while building the sine ROM
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // One ROM entry: 32767 * sin(2*pi*k/depth), Taylor series in Q30
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                             input int unsigned depth);
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] mag;
        logic [63:0] denom;
        d    = 64'(depth);
        t    = 64'(k) << 2;
        quad = udiv64(t, d);
        rem  = t - quad * d;
        if (quad[0])
            rem = d - rem;
        x    = udiv64(HALF_PI_Q30 * rem + (d >> 1), d);
        sum  = $signed(x);
        term = x;
        for (int n = 1; n <= 7; n++)
        begin
            term  = (term * x) >> 30;
            term  = (term * x) >> 30;
            denom = 64'((2 * n) * (2 * n + 1));
            term  = udiv64(term, denom);
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        if (sum > $signed(Q30_ONE))
            sum = $signed(Q30_ONE);
        mag = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (quad >= 64'd2)
            return SAMPLE_W'(-$signed(mag));
        return SAMPLE_W'(mag);
    endfunction

endpackage

`default_nettype wire

@@ design/rm_sine_rom.sv @@
`default_nettype none

// Read-only sine table, registered read
module rm_sine_rom #(
    parameter int DEPTH = rm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic signed [rm_pkg::SAMPLE_W-1:0]       rd_data
);

    typedef logic signed [rm_pkg::SAMPLE_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < DEPTH; k++)
            r[k] = rm_pkg::sine_entry(k, DEPTH);
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic signed [rm_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= ROM[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/rm_datapath.sv @@
`default_nettype none

module rm_datapath #(
    parameter int PHASE_BITS       = rm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = rm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire rm_pkg::rm_cmd_t                         cmd,
    input  wire logic signed [rm_pkg::SAMPLE_W-1:0]      sample_in,
    input  wire logic                                    cfg_we,
    input  wire logic [rm_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [rm_pkg::CFG_DATA_W-1:0]           cfg_data,
    output logic signed [rm_pkg::SAMPLE_W-1:0]          sample_out
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int SCL_W  = PHASE_BITS + IDX_W;
    localparam int Y_W    = rm_pkg::PROD_W - rm_pkg::FRAC_W;

    logic [rm_pkg::STEP_W-1:0]           phase_step_reg;
    logic [rm_pkg::GAIN_W-1:0]           carrier_gain_reg;
    logic [PHASE_BITS-1:0]               phase_reg;
    logic [PHASE_BITS-1:0]               phase_next;
    logic [PHASE_BITS-1:0]               step_ext;
    logic signed [rm_pkg::SAMPLE_W-1:0]  sample_reg;
    logic signed [rm_pkg::SAMPLE_W-1:0]  sample2_reg;
    logic signed [rm_pkg::GS_W-1:0]      gs_reg;
    logic signed [rm_pkg::SAMPLE_W-1:0]  out_reg;
    logic signed [rm_pkg::SAMPLE_W-1:0]  sine;
    logic [SCL_W-1:0]                    phase_scaled;
    logic [IDX_W-1:0]                    rom_idx;
    logic signed [rm_pkg::GS_W-1:0]      gs_next;
    logic signed [rm_pkg::PROD_W-1:0]    prod;
    logic signed [rm_pkg::PROD_W-1:0]    prod_adj;
    logic signed [Y_W-1:0]               y;
    logic signed [rm_pkg::SAMPLE_W-1:0]  out_next;

    // Step register is 32 bits; the accumulator keeps PHASE_BITS of the sum
    generate
        if (PHASE_BITS > rm_pkg::STEP_W) begin : g_step_wide
            assign step_ext = {{(PHASE_BITS - rm_pkg::STEP_W){1'b0}}, phase_step_reg};
        end else begin : g_step_narrow
            assign step_ext = phase_step_reg[PHASE_BITS-1:0];
        end
    endgenerate

    assign phase_next = phase_reg + step_ext;

    // idx = phase * depth >> PHASE_BITS (a plain slice for a power-of-two depth)
    assign phase_scaled = SCL_W'(phase_reg) * SCL_W'(SINE_TABLE_DEPTH);
    assign rom_idx      = phase_scaled[SCL_W-1:PHASE_BITS];

    rm_sine_rom #(
        .DEPTH   (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .rd_en   (cmd.load),
        .rd_addr (rom_idx),
        .rd_data (sine)
    );

    assign gs_next = $signed({1'b0, carrier_gain_reg}) * sine;

    // Q20.29 product, truncated toward zero, then clamped to 16 bits
    always_comb
    begin
        prod     = gs_reg * sample2_reg;
        prod_adj = prod;
        if (prod[rm_pkg::PROD_W-1])
            prod_adj = prod + rm_pkg::PROD_W'((64'd1 << rm_pkg::FRAC_W) - 64'd1);
        y = prod_adj[rm_pkg::PROD_W-1:rm_pkg::FRAC_W];
        if (y > Y_W'(32767))
            out_next = 16'sh7fff;
        else if (y < -Y_W'(32768))
            out_next = 16'sh8000;
        else
            out_next = y[rm_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= rm_pkg::PHASE_STEP_RST;
            carrier_gain_reg <= rm_pkg::CARRIER_GAIN_RST;
            phase_reg        <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == rm_pkg::REG_PHASE_STEP)
                phase_step_reg <= cfg_data[rm_pkg::STEP_W-1:0];
            if (cfg_we && cfg_index == rm_pkg::REG_CARRIER_GAIN)
                carrier_gain_reg <= cfg_data[rm_pkg::GAIN_W-1:0];
            if (cmd.load)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= sample_in;
        if (cmd.gain)
        begin
            gs_reg      <= gs_next;
            sample2_reg <= sample_reg;
        end
        if (cmd.mix)
            out_reg <= out_next;
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

@@ design/rm_ctrl.sv @@
`default_nettype none

module rm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rm_pkg::rm_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MIX
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    // Output slot can take a result this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (out_free)
                begin
                    cmd.mix    = 1'b1;
                    in_ready   = 1'b1;
                    state_next = in_valid ? ST_GAIN : ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        cmd.load = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.mix)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/ring_modulator.sv @@
// Ring modulator with a sine carrier from a phase accumulator.
// Input stream s_axis: one signed 16-bit audio sample per request.
// Output stream m_axis: one signed 16-bit sample per input request,
//   sample * carrier_gain * sin(phase), truncated toward zero, saturated.
// Config channel cfg_*: index 0 writes phase_step (32 bits), index 1 writes
//   carrier_gain (low 16 bits, unsigned Q2.14); other indexes are dropped.
//   cfg_ready is always high; write only while the block is idle.
// Path: a taken sample goes through the sine ROM read, the gain multiply
//   and the sample multiply with saturation into the output register.
// Overlap: the gain multiply runs in the GAIN state, the sample multiply in MIX;
//   the next sample is taken during MIX, so its ROM read overlaps the second.
// Each request uses the current phase, then the phase advances by
//   phase_step, so the carrier runs on without a break between samples.
// Reset: phase clears to zero, phase_step to 300 Hz at 8 kHz, gain to 1.0,
//   output empty.
// Stall: one result waits in the output register while the next sample is
//   taken and worked; if that result is still held, s_axis_tready drops.
`default_nettype none

module ring_modulator #(
    parameter int PHASE_BITS       = rm_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = rm_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input samples
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rm_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [15:0] sample_in
    // Output samples
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rm_pkg::SAMPLE_W-1:0]            m_axis_tdata,  // [15:0] sample_out
    // Register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rm_pkg::rm_cmd_t                    cmd;
    logic signed [rm_pkg::SAMPLE_W-1:0] sample_out;

    assign cfg_ready = 1'b1;

    rm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    rm_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  ($signed(s_axis_tdata)),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out)
    );

    assign m_axis_tdata = $unsigned(sample_out);

endmodule

`default_nettype wire
